>>> rtl/bc1_pkg.sv
// shared types and constants for the bc1 block decoder
package bc1_pkg;

  localparam int unsigned COORD_W = 12;
  localparam int unsigned SIZE_REG_W = 11;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned PIX_PER_BLOCK = 16;
  localparam int unsigned PIX_CNT_W = 4;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [7:0] ALPHA_CLEAR = 8'd0;

  // register index, taken from paddr[2]
  localparam logic REG_WIDTH = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } colour_t;

  typedef struct packed {
    colour_t [3:0]        palette;
    logic [31:0]          index_bits;
    logic [COORD_W-1:0]   x_base;
    logic [COORD_W-1:0]   y_base;
    logic                 last_img;
  } block_t;

endpackage

>>> rtl/bc1_if.sv
// channel interfaces for compressed blocks and decoded pixels
interface bc1_block_if;
  logic        valid;
  logic        ready;
  logic [15:0] endpoint_a;
  logic [15:0] endpoint_b;
  logic [31:0] index_bits;

  modport source (output valid, endpoint_a, endpoint_b, index_bits, input ready);
  modport sink (input valid, endpoint_a, endpoint_b, index_bits, output ready);
endinterface

interface bc1_pixel_if;
  logic        valid;
  logic        ready;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic        last_of_block;
  logic        last_of_image;

  modport source (output valid, pixel_x, pixel_y, red, green, blue, alpha,
                  last_of_block, last_of_image, input ready);
  modport sink (input valid, pixel_x, pixel_y, red, green, blue, alpha,
                last_of_block, last_of_image, output ready);
endinterface

>>> rtl/bc1_front.sv
// block intake: palette build and block position tracking
module bc1_front #(
  parameter int unsigned MAX_BLOCKS_PER_SIDE = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [bc1_pkg::SIZE_REG_W-1:0]    width_in_blocks,
  input  logic [bc1_pkg::SIZE_REG_W-1:0]    height_in_blocks,
  bc1_block_if.sink                         block,
  input  logic                              full,
  output logic                              push,
  output bc1_pkg::block_t                   entry
);

  localparam int unsigned CW = (MAX_BLOCKS_PER_SIDE > 1) ? $clog2(MAX_BLOCKS_PER_SIDE) : 1;
  localparam int unsigned SW = 13;
  localparam logic [SW-1:0] MAX_SIZE = SW'(MAX_BLOCKS_PER_SIDE);
  localparam logic [9:0] RECIP3 = 10'd683;

  logic [CW-1:0] block_column;
  logic [CW-1:0] block_row;
  logic [CW-1:0] block_column_next;
  logic [CW-1:0] block_row_next;
  logic [SW-1:0] w_raw, h_raw, w_eff, h_eff;
  logic          last_col, last_row, four_colour;
  bc1_pkg::colour_t ca, cb;

  function automatic logic [7:0] third(input logic [7:0] p, input logic [7:0] q);
    logic [9:0]  s;
    logic [19:0] m;
    s = {1'b0, p, 1'b0} + {2'b00, q};
    m = s * RECIP3;
    return m[18:11];
  endfunction

  function automatic logic [7:0] half(input logic [7:0] p, input logic [7:0] q);
    logic [8:0] s;
    s = {1'b0, p} + {1'b0, q};
    return s[8:1];
  endfunction

  always_comb begin
    w_raw = SW'(width_in_blocks);
    h_raw = SW'(height_in_blocks);
    if (w_raw == '0) w_eff = SW'(1);
    else if (w_raw > MAX_SIZE) w_eff = MAX_SIZE;
    else w_eff = w_raw;
    if (h_raw == '0) h_eff = SW'(1);
    else if (h_raw > MAX_SIZE) h_eff = MAX_SIZE;
    else h_eff = h_raw;
    last_col = (SW'(block_column) + SW'(1)) >= w_eff;
    last_row = (SW'(block_row) + SW'(1)) >= h_eff;
    if (last_col) begin
      block_column_next = '0;
      block_row_next = last_row ? '0 : block_row + CW'(1);
    end else begin
      block_column_next = block_column + CW'(1);
      block_row_next = block_row;
    end
  end

  always_comb begin
    ca.red   = {block.endpoint_a[4:0], 3'b000};
    ca.green = {block.endpoint_a[10:5], 2'b00};
    ca.blue  = {block.endpoint_a[15:11], 3'b000};
    ca.alpha = bc1_pkg::ALPHA_OPAQUE;
    cb.red   = {block.endpoint_b[4:0], 3'b000};
    cb.green = {block.endpoint_b[10:5], 2'b00};
    cb.blue  = {block.endpoint_b[15:11], 3'b000};
    cb.alpha = bc1_pkg::ALPHA_OPAQUE;
    four_colour = block.endpoint_a > block.endpoint_b;

    entry.palette[0] = ca;
    entry.palette[1] = cb;
    if (four_colour) begin
      entry.palette[2].red   = third(ca.red, cb.red);
      entry.palette[2].green = third(ca.green, cb.green);
      entry.palette[2].blue  = third(ca.blue, cb.blue);
      entry.palette[2].alpha = bc1_pkg::ALPHA_OPAQUE;
      entry.palette[3].red   = third(cb.red, ca.red);
      entry.palette[3].green = third(cb.green, ca.green);
      entry.palette[3].blue  = third(cb.blue, ca.blue);
      entry.palette[3].alpha = bc1_pkg::ALPHA_OPAQUE;
    end else begin
      entry.palette[2].red   = half(ca.red, cb.red);
      entry.palette[2].green = half(ca.green, cb.green);
      entry.palette[2].blue  = half(ca.blue, cb.blue);
      entry.palette[2].alpha = bc1_pkg::ALPHA_OPAQUE;
      entry.palette[3].red   = 8'd0;
      entry.palette[3].green = 8'd0;
      entry.palette[3].blue  = 8'd0;
      entry.palette[3].alpha = bc1_pkg::ALPHA_CLEAR;
    end
    entry.index_bits = block.index_bits;
    entry.x_base = bc1_pkg::COORD_W'({block_column, 2'b00});
    entry.y_base = bc1_pkg::COORD_W'({block_row, 2'b00});
    entry.last_img = last_col && last_row;
  end

  assign block.ready = !full;
  assign push = block.valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_column <= '0;
      block_row <= '0;
    end else if (push) begin
      block_column <= block_column_next;
      block_row <= block_row_next;
    end
  end

endmodule

>>> rtl/bc1_fifo.sv
// two-entry block queue between intake and pixel output
module bc1_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bc1_pkg::block_t entry_in,
  output logic            full,
  input  logic            pop,
  output bc1_pkg::block_t entry_out,
  output logic            empty
);

  bc1_pkg::block_t mem [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign full = count == 2'd2;
  assign empty = count == 2'd0;
  assign entry_out = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= entry_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/bc1_back.sv
// pixel expansion: sixteen pixels per queued block into an output register
module bc1_back (
  input  logic            clk,
  input  logic            rst,
  input  bc1_pkg::block_t entry,
  input  logic            empty,
  output logic            pop,
  bc1_pixel_if.source     pixel
);

  logic [bc1_pkg::PIX_CNT_W-1:0] pix_cnt;
  logic                          load;
  logic                          fire;
  logic                          last_pix;
  logic [1:0]                    sel;
  logic [1:0]                    blk_row;

  assign load = !pixel.valid || pixel.ready;
  assign fire = load && !empty;
  assign last_pix = pix_cnt == bc1_pkg::PIX_CNT_W'(bc1_pkg::PIX_PER_BLOCK - 1);
  assign pop = fire && last_pix;
  assign sel = entry.index_bits[{pix_cnt, 1'b0} +: 2];
  // rows come out as 1,0,3,2
  assign blk_row = {pix_cnt[3], !pix_cnt[2]};

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_cnt <= '0;
      pixel.valid <= 1'b0;
    end else begin
      if (fire) pix_cnt <= pix_cnt + bc1_pkg::PIX_CNT_W'(1);
      if (load) pixel.valid <= !empty;
    end
    if (fire) begin
      pixel.pixel_x <= entry.x_base | bc1_pkg::COORD_W'(pix_cnt[1:0]);
      pixel.pixel_y <= entry.y_base | bc1_pkg::COORD_W'(blk_row);
      pixel.red <= entry.palette[sel].red;
      pixel.green <= entry.palette[sel].green;
      pixel.blue <= entry.palette[sel].blue;
      pixel.alpha <= entry.palette[sel].alpha;
      pixel.last_of_block <= last_pix;
      pixel.last_of_image <= last_pix && entry.last_img;
    end
  end

endmodule

>>> rtl/bc1_block_decoder.sv
// top level of the bc1 block decoder
//
//   channel  | dir | handshake         | payload
//   block    | in  | valid/ready       | endpoint_a, endpoint_b, index_bits
//   pixel    | out | valid/ready       | pixel_x, pixel_y, rgba, last flags
//   apb      | in  | psel/penable      | width_in_blocks @0, height_in_blocks @4
//
// one block in, sixteen pixels out through the single pixel output register
// at one pixel per cycle while pixel ready holds; a two-block queue lets intake
// run ahead by up to two blocks; an accepted block is queued, then its first
// pixel goes to the pixel output register
// synchronous reset clears counters, queue and output valid; sizes return to 1
module bc1_block_decoder #(
  parameter int unsigned MAX_BLOCKS_PER_SIDE = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  bc1_block_if.sink                       block,
  bc1_pixel_if.source                     pixel,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bc1_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [bc1_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [bc1_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  logic [bc1_pkg::SIZE_REG_W-1:0] width_in_blocks;
  logic [bc1_pkg::SIZE_REG_W-1:0] height_in_blocks;
  logic            push, pop, full, empty;
  bc1_pkg::block_t entry_in, entry_out;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_in_blocks <= bc1_pkg::SIZE_REG_W'(1);
      height_in_blocks <= bc1_pkg::SIZE_REG_W'(1);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        bc1_pkg::REG_WIDTH: width_in_blocks <= pwdata[bc1_pkg::SIZE_REG_W-1:0];
        bc1_pkg::REG_HEIGHT: height_in_blocks <= pwdata[bc1_pkg::SIZE_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      bc1_pkg::REG_WIDTH: prdata = bc1_pkg::APB_DATA_W'(width_in_blocks);
      bc1_pkg::REG_HEIGHT: prdata = bc1_pkg::APB_DATA_W'(height_in_blocks);
      default: prdata = '0;
    endcase
  end

  bc1_front #(
    .MAX_BLOCKS_PER_SIDE(MAX_BLOCKS_PER_SIDE)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .width_in_blocks(width_in_blocks),
    .height_in_blocks(height_in_blocks),
    .block(block),
    .full(full),
    .push(push),
    .entry(entry_in)
  );

  bc1_fifo u_fifo (
    .clk(clk),
    .rst(rst),
    .push(push),
    .entry_in(entry_in),
    .full(full),
    .pop(pop),
    .entry_out(entry_out),
    .empty(empty)
  );

  bc1_back u_back (
    .clk(clk),
    .rst(rst),
    .entry(entry_out),
    .empty(empty),
    .pop(pop),
    .pixel(pixel)
  );

endmodule

>>> rtl/bc1_checker.sv
// port-level checks on the bc1 block decoder, bound to the top level
module bc1_checker (
  input logic        clk,
  input logic        rst,
  input logic        pix_valid,
  input logic        pix_ready,
  input logic [11:0] pixel_x,
  input logic [11:0] pixel_y,
  input logic [7:0]  red,
  input logic [7:0]  alpha,
  input logic        last_of_block,
  input logic        last_of_image
);

  // a stalled pixel transaction holds its position, red, alpha and last_of_block
  a_pix_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_ready |=> pix_valid && $stable(pixel_x) && $stable(pixel_y)
      && $stable(red) && $stable(alpha) && $stable(last_of_block))
    else $error("pixel transaction changed while stalled");

  a_img_in_blk: assert property (@(posedge clk) disable iff (rst)
    pix_valid && last_of_image |-> last_of_block)
    else $error("last_of_image without last_of_block");

  // row swap: the block's final pixel sits in row 2, column 3
  a_blk_corner: assert property (@(posedge clk) disable iff (rst)
    pix_valid && last_of_block |-> pixel_x[1:0] == 2'd3 && pixel_y[1:0] == 2'd2)
    else $error("last_of_block on wrong pixel position");

  a_rst_idle: assert property (@(posedge clk)
    rst |=> !pix_valid)
    else $error("pixel valid right after reset");

endmodule

bind bc1_block_decoder bc1_checker u_bc1_checker (
  .clk(clk),
  .rst(rst),
  .pix_valid(pixel.valid),
  .pix_ready(pixel.ready),
  .pixel_x(pixel.pixel_x),
  .pixel_y(pixel.pixel_y),
  .red(pixel.red),
  .alpha(pixel.alpha),
  .last_of_block(pixel.last_of_block),
  .last_of_image(pixel.last_of_image)
);
